// ===== rtl/core/tbps_pkg.sv =====
// shared constants, codes and controller/datapath interface types of the packet shaper
package tbps_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_REL     = 32;
   localparam int REL_W       = $clog2(MAX_REL + 1);

   localparam int LEN_W    = 16;
   localparam int US_W     = 16;
   localparam int RATE_W   = 17;
   localparam int BUCKET_W = 23;
   localparam int TOK_W    = 32;
   localparam int KIND_W   = 2;
   localparam int PROD_W   = US_W + RATE_W;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = LEN_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BUCKET_W;

   localparam logic [RATE_W-1:0]   RESET_RATE   = RATE_W'(100);
   localparam logic [BUCKET_W-1:0] RESET_BUCKET = BUCKET_W'(64000);

   localparam logic [KIND_W-1:0] EV_ACCEPT  = 2'd0;
   localparam logic [KIND_W-1:0] EV_DROP    = 2'd1;
   localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUCKET = 2'd1;

   typedef struct packed {
      logic load;
      logic enq;
      logic mul;
      logic add;
      logic rel;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic can_rel;
      logic pend_valid;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/tbps_ctrl.sv =====
// sequencing state machine of the packet shaper
module tbps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tick,
   output logic              req_tready,
   input  tbps_pkg::stat_type stat,
   output tbps_pkg::cmd_type  cmd
);
   import tbps_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ENQ  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_REL  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       slot_ok;

   assign slot_ok = !stat.pend_valid || stat.out_free;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = req_tick ? ST_MUL : ST_ENQ;
            end
         end
         ST_ENQ: begin
            if (stat.out_free) begin
               cmd.enq  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_REL;
         end
         ST_REL: begin
            if (!stat.can_rel) begin
               state_in = ST_FIN;
            end else if (slot_ok) begin
               cmd.rel = 1'b1;
            end
         end
         ST_FIN: begin
            if (slot_ok) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/tbps_dpath.sv =====
// token arithmetic, length queue, pending release and output register
module tbps_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  tbps_pkg::cmd_type                   cmd,
   output tbps_pkg::stat_type                  stat,
   input  logic [tbps_pkg::LEN_W-1:0]          req_len,
   input  logic [tbps_pkg::US_W-1:0]           req_us,
   input  logic                                csr_write,
   input  logic [tbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbps_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [tbps_pkg::KIND_W-1:0]         rsp_kind,
   output logic [tbps_pkg::LEN_W-1:0]          rsp_len,
   output logic                                rsp_tlast
);
   import tbps_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   logic [RATE_W-1:0]   rate_ff;
   logic [BUCKET_W-1:0] bucket_ff;
   logic [TOK_W-1:0]    tokens_ff, tokens_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [REL_W-1:0]    nrel_ff, nrel_in;
   logic [LEN_W-1:0]    len_ff;
   logic [US_W-1:0]     us_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [LEN_W-1:0]    fifo_mem [QUEUE_DEPTH];

   logic                pend_ff, pend_in;
   logic [LEN_W-1:0]    pend_len_ff;
   logic                out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]   out_kind_ff;
   logic [LEN_W-1:0]    out_len_ff;
   logic                out_last_ff;

   logic [LEN_W-1:0]    head_len;
   logic [SUM_W-1:0]    tail_sum;
   logic [PTR_W-1:0]    tail;
   logic                full;
   logic [TOK_W:0]      tok_sum;
   logic                load_out;

   assign head_len = fifo_mem[head_ff];
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
   assign tok_sum  = {1'b0, tokens_ff} + (TOK_W + 1)'(prod_ff[PROD_W-1:3]);

   assign stat.out_free   = !out_valid_ff || rsp_tready;
   assign stat.pend_valid = pend_ff;
   assign stat.can_rel    = (count_ff != '0) && (nrel_ff != REL_W'(MAX_REL)) &&
                            (TOK_W'(head_len) <= tokens_ff);

   assign load_out = cmd.enq || ((cmd.rel || cmd.fin) && pend_ff);

   always_comb begin
      tokens_in = tokens_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      nrel_in   = nrel_ff;
      pend_in   = pend_ff;
      if (cmd.enq && !full) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.add) begin
         tokens_in = tok_sum[TOK_W] ? '1 : tok_sum[TOK_W-1:0];
         nrel_in   = '0;
      end
      if (cmd.rel) begin
         tokens_in = tokens_ff - TOK_W'(head_len);
         head_in   = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in  = count_ff - 1'b1;
         nrel_in   = nrel_ff + 1'b1;
         pend_in   = 1'b1;
      end
      if (cmd.fin) begin
         pend_in = 1'b0;
         // cap only once the queue has drained
         if (count_ff == '0 && tokens_ff >= TOK_W'(bucket_ff)) begin
            tokens_in = TOK_W'(bucket_ff);
         end
      end
      out_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= RESET_RATE;
         bucket_ff    <= RESET_BUCKET;
         tokens_ff    <= TOK_W'(RESET_BUCKET);
         head_ff      <= '0;
         count_ff     <= '0;
         nrel_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == REG_RATE) begin
            rate_ff <= csr_data[RATE_W-1:0];
         end
         if (csr_write && csr_index == REG_BUCKET) begin
            bucket_ff <= csr_data;
         end
         tokens_ff    <= tokens_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         nrel_ff      <= nrel_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff <= req_len;
         us_ff  <= req_us;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(us_ff) * PROD_W'(rate_ff);
      end
      if (cmd.enq && !full) begin
         fifo_mem[tail] <= len_ff;
      end
      if (cmd.rel) begin
         pend_len_ff <= head_len;
      end
      if (cmd.enq) begin
         out_kind_ff <= full ? EV_DROP : EV_ACCEPT;
         out_len_ff  <= '0;
         out_last_ff <= 1'b1;
      end else if (load_out) begin
         out_kind_ff <= EV_RELEASE;
         out_len_ff  <= pend_len_ff;
         out_last_ff <= cmd.fin;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_len    = out_len_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/core/token_bucket_packet_shaper_core.sv =====
// top level of the token-bucket packet shaper: state machine, datapath and checks
//
//  channel | direction | transfer when          | contents
//  --------+-----------+------------------------+---------------------------------------
//  req     | in        | req_tvalid & req_tready | tuser action, tdata length / elapsed
//  rsp     | out       | rsp_tvalid & rsp_tready | tuser kind, tdata length, tlast final event
//  csr     | in        | csr_valid & csr_ready   | register index and write data
//
//  an enqueue is accepted, then writes the queue and its event into the output register once free
//  a tick runs multiply, saturating add, then one release per cycle through the head-length
//  compare while the pending or output slot is free, then a closing step for the cap
//  releases are held one deep so the final one can be marked with tlast
//  reset is synchronous; the queue contents are not cleared, only its pointers
//  a stalled rsp side holds the release loop once both output and pending slots are full
module token_bucket_packet_shaper_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tbps_pkg::REQ_DATA_W-1:0]     req_tdata,  // packet_length, elapsed_us
   input  logic                                req_tuser,  // action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbps_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // released_length
   output logic [tbps_pkg::KIND_W-1:0]         rsp_tuser,  // event_kind
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbps_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tbps_pkg::*;

   cmd_type           cmd;
   stat_type          stat;

   // configuration is always taken
   assign csr_ready = 1'b1;

   tbps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tick   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tbps_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_len    (req_tdata[LEN_W-1:0]),
      .req_us     (req_tdata[LEN_W+US_W-1:LEN_W]),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_kind   (rsp_tuser),
      .rsp_len    (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // no event code beyond release ever leaves
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == EV_ACCEPT || rsp_tuser == EV_DROP || rsp_tuser == EV_RELEASE))
      else $error("illegal event kind");

   // accept and drop events carry no length and close their item
   a_enq_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != EV_RELEASE) |-> (rsp_tdata == '0 && rsp_tlast))
      else $error("enqueue event malformed");

   // a held release never outlives its tick
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stat.pend_valid)
      else $error("pending release while idle");

   // the datapath is only commanded one operation at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.enq, cmd.mul, cmd.add, cmd.rel, cmd.fin}))
      else $error("overlapping commands");

endmodule
